// ===== design/nfjt_pkg.sv =====
// shared constants of the nearest-first job table
// no dependencies
package nfjt_pkg;

    localparam int Y_BITS   = 8;
    localparam int TAG_BITS = 16;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_TAKE   = 1'b1;

endpackage

// ===== design/nfjt_if.sv =====
// valid/ready channel interfaces for items into and results out of the job table
// depends on nfjt_pkg
interface nfjt_in_if #(
    parameter int COORD_BITS = 24
);
    logic                              valid;
    logic                              ready;
    logic                              func;
    logic signed [COORD_BITS-1:0]      job_x;
    logic [nfjt_pkg::Y_BITS-1:0]       job_y;
    logic signed [COORD_BITS-1:0]      job_z;
    logic [nfjt_pkg::TAG_BITS-1:0]     job_tag;
    logic signed [COORD_BITS-1:0]      view_x;
    logic signed [COORD_BITS-1:0]      view_y;
    logic signed [COORD_BITS-1:0]      view_z;

    modport source (
        output valid, func, job_x, job_y, job_z, job_tag, view_x, view_y, view_z,
        input  ready
    );
    modport sink (
        input  valid, func, job_x, job_y, job_z, job_tag, view_x, view_y, view_z,
        output ready
    );
endinterface

interface nfjt_out_if #(
    parameter int COORD_BITS = 24,
    parameter int LEFT_BITS  = 7
);
    logic                              valid;
    logic                              ready;
    logic                              dropped;
    logic                              found;
    logic [nfjt_pkg::TAG_BITS-1:0]     out_tag;
    logic signed [COORD_BITS-1:0]      out_x;
    logic [nfjt_pkg::Y_BITS-1:0]       out_y;
    logic signed [COORD_BITS-1:0]      out_z;
    logic [2*COORD_BITS:0]             out_dist_sq;
    logic [LEFT_BITS-1:0]              jobs_left;

    modport source (
        output valid, dropped, found, out_tag, out_x, out_y, out_z, out_dist_sq, jobs_left,
        input  ready
    );
    modport sink (
        input  valid, dropped, found, out_tag, out_x, out_y, out_z, out_dist_sq, jobs_left,
        output ready
    );
endinterface

// ===== design/nearest_first_job_table_core.sv =====
// insert: the result is registered once the output register is free, and only then is the
// next item taken; take on n jobs: the job ram's read port reads one entry per cycle, the
// distance pipeline picks the nearest, the swap moves the last entry in; empty take as insert
// synchronous active-low reset empties the table and the output register at once
// depends on nfjt_pkg, nfjt_if, nfjt_ram
module nearest_first_job_table_core #(
    parameter int TABLE_DEPTH = 64,
    parameter int COORD_BITS  = 24
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    nfjt_in_if.sink  i_in,
    nfjt_out_if.source o_out
);
    localparam int C     = COORD_BITS;
    localparam int YB    = nfjt_pkg::Y_BITS;
    localparam int TB    = nfjt_pkg::TAG_BITS;
    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int CW    = $clog2(TABLE_DEPTH + 1);
    localparam int DW    = C + 2;
    localparam int PW    = 2 * DW;
    localparam int SW    = PW + 2;
    localparam int OW    = 2 * C + 1;
    localparam int ENT_W = 2 * C + YB + TB;
    localparam int Z_LO  = TB;
    localparam int Y_LO  = TB + C;
    localparam int X_LO  = TB + C + YB;
    localparam logic [SW-1:0] DIST_MAX = SW'({OW{1'b1}});

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SWAP, S_EMIT} t_state;

    t_state r_state;
    logic [CW-1:0] r_count;
    logic [AW-1:0] r_rd_idx;
    logic          r_issue;
    logic          r_res_found;
    logic          r_res_dropped;
    logic signed [C-1:0] r_vx, r_vy, r_vz;

    logic              r_o_valid, r_o_dropped, r_o_found;
    logic [TB-1:0]     r_o_tag;
    logic [C-1:0]      r_o_x, r_o_z;
    logic [YB-1:0]     r_o_y;
    logic [OW-1:0]     r_o_dist;
    logic [CW-1:0]     r_o_left;

    logic r_v0, r_v1, r_v2;
    logic r_lst0, r_lst1, r_lst2;
    logic [AW-1:0] r_idx0, r_idx1, r_idx2;
    logic [ENT_W-1:0] r_ent1, r_ent2, r_last_ent, r_best_ent;
    logic [PW-1:0] r_sqx, r_sqy, r_sqz;
    logic [SW-1:0] r_sum, r_best_d;
    logic [AW-1:0] r_best_idx;

    logic          accept, rd_en, we, out_free, last_rd;
    logic [AW-1:0] waddr, last_idx;
    logic [ENT_W-1:0] wdata, rdata;
    logic signed [DW-1:0] dx, dy, dz;
    logic signed [PW-1:0] sqx, sqy, sqz;
    logic [SW-1:0] sum_next;

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && (r_state == S_IDLE);
    assign out_free   = !r_o_valid || o_out.ready;
    assign last_idx   = AW'(r_count - CW'(1));
    assign rd_en      = (r_state == S_SCAN) && r_issue;
    assign last_rd    = (r_rd_idx == last_idx);

    // one write port: appends on insert unless the table is full, moves the last entry on take
    always_comb begin
        we    = 1'b0;
        waddr = r_best_idx;
        wdata = r_last_ent;
        if (accept && i_in.func == nfjt_pkg::FUNC_INSERT
            && r_count < CW'(TABLE_DEPTH)) begin
            we    = 1'b1;
            waddr = r_count[AW-1:0];
            wdata = {i_in.job_x, i_in.job_y, i_in.job_z, i_in.job_tag};
        end else if (r_state == S_SWAP) begin
            we = 1'b1;
        end
    end

    nfjt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (rd_en),
        .i_raddr (r_rd_idx),
        .o_rdata (rdata)
    );

    // distance pipeline
    assign dx = $signed({{2{rdata[X_LO+C-1]}}, rdata[X_LO +: C]})
              - $signed({{2{r_vx[C-1]}}, r_vx});
    assign dy = $signed({{(DW-YB){1'b0}}, rdata[Y_LO +: YB]})
              - $signed({{2{r_vy[C-1]}}, r_vy});
    assign dz = $signed({{2{rdata[Z_LO+C-1]}}, rdata[Z_LO +: C]})
              - $signed({{2{r_vz[C-1]}}, r_vz});
    assign sqx = dx * dx;
    assign sqy = dy * dy;
    assign sqz = dz * dz;
    assign sum_next = SW'(r_sqx) + SW'(r_sqy) + SW'(r_sqz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v0 <= rd_en;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx0 <= r_rd_idx;
        r_lst0 <= last_rd;
        r_sqx  <= PW'(sqx);
        r_sqy  <= PW'(sqy);
        r_sqz  <= PW'(sqz);
        r_ent1 <= rdata;
        r_idx1 <= r_idx0;
        r_lst1 <= r_lst0;
        r_sum  <= sum_next;
        r_ent2 <= r_ent1;
        r_idx2 <= r_idx1;
        r_lst2 <= r_lst1;
        if (r_v2) begin
            if (r_idx2 == '0 || r_sum < r_best_d) begin
                r_best_d   <= r_sum;
                r_best_idx <= r_idx2;
                r_best_ent <= r_ent2;
            end
            if (r_lst2) begin
                r_last_ent <= r_ent2;
            end
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_issue   <= 1'b0;
            r_rd_idx  <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && o_out.ready && r_state != S_EMIT) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (i_in.func)
                            nfjt_pkg::FUNC_INSERT: begin
                                r_res_found <= 1'b0;
                                r_state     <= S_EMIT;
                                if (r_count < CW'(TABLE_DEPTH)) begin
                                    r_res_dropped <= 1'b0;
                                    r_count       <= r_count + CW'(1);
                                end else begin
                                    r_res_dropped <= 1'b1;
                                end
                            end
                            nfjt_pkg::FUNC_TAKE: begin
                                r_res_dropped <= 1'b0;
                                if (r_count != '0) begin
                                    r_res_found <= 1'b1;
                                    r_vx        <= i_in.view_x;
                                    r_vy        <= i_in.view_y;
                                    r_vz        <= i_in.view_z;
                                    r_rd_idx    <= '0;
                                    r_issue     <= 1'b1;
                                    r_state     <= S_SCAN;
                                end else begin
                                    r_res_found <= 1'b0;
                                    r_state     <= S_EMIT;
                                end
                            end
                            default: begin
                                r_res_dropped <= 1'b0;
                                r_res_found   <= 1'b0;
                                r_state       <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_issue) begin
                        r_rd_idx <= r_rd_idx + AW'(1);
                        if (last_rd) begin
                            r_issue <= 1'b0;
                        end
                    end
                    if (r_v2 && r_lst2) begin
                        r_state <= S_SWAP;
                    end
                end
                S_SWAP: begin
                    r_count <= r_count - CW'(1);
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_o_valid   <= 1'b1;
                        r_o_dropped <= r_res_dropped;
                        r_o_found   <= r_res_found;
                        r_o_left    <= r_count;
                        if (r_res_found) begin
                            r_o_tag  <= r_best_ent[TB-1:0];
                            r_o_x    <= r_best_ent[X_LO +: C];
                            r_o_y    <= r_best_ent[Y_LO +: YB];
                            r_o_z    <= r_best_ent[Z_LO +: C];
                            r_o_dist <= (r_best_d > DIST_MAX) ? DIST_MAX[OW-1:0]
                                                              : r_best_d[OW-1:0];
                        end else begin
                            r_o_tag  <= '0;
                            r_o_x    <= '0;
                            r_o_y    <= '0;
                            r_o_z    <= '0;
                            r_o_dist <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid       = r_o_valid;
    assign o_out.dropped     = r_o_dropped;
    assign o_out.found       = r_o_found;
    assign o_out.out_tag     = r_o_tag;
    assign o_out.out_x       = r_o_x;
    assign o_out.out_y       = r_o_y;
    assign o_out.out_z       = r_o_z;
    assign o_out.out_dist_sq = r_o_dist;
    assign o_out.jobs_left   = r_o_left;
endmodule

// ===== design/nfjt_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module nfjt_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/nfjt_chk.sv =====
// port-level checks on the result channel of the job table, bound to the core module
// depends on nearest_first_job_table_core, nfjt_if
module nfjt_chk #(
    parameter int TABLE_DEPTH = 64,
    parameter int COORD_BITS  = 24,
    parameter int LEFT_BITS   = 7
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_valid,
    input logic                    i_ready,
    input logic                    i_dropped,
    input logic                    i_found,
    input logic [15:0]             i_tag,
    input logic [2*COORD_BITS:0]   i_dist,
    input logic [LEFT_BITS-1:0]    i_left
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_tag) && $stable(i_dist)
                                && $stable(i_left) && $stable(i_found))
        else $error("result changed while stalled");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_left <= LEFT_BITS'(TABLE_DEPTH))
        else $error("jobs_left above table depth");

    a_found_not_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_found |-> !i_dropped)
        else $error("take result flagged as dropped");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_dropped |-> i_left == LEFT_BITS'(TABLE_DEPTH))
        else $error("drop reported on a table that is not full");

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_found |-> i_tag == '0 && i_dist == '0)
        else $error("job fields set without a found job");
endmodule

bind nearest_first_job_table_core nfjt_chk #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .COORD_BITS  (COORD_BITS),
    .LEFT_BITS   ($clog2(TABLE_DEPTH + 1))
) u_nfjt_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (o_out.valid),
    .i_ready   (o_out.ready),
    .i_dropped (o_out.dropped),
    .i_found   (o_out.found),
    .i_tag     (o_out.out_tag),
    .i_dist    (o_out.out_dist_sq),
    .i_left    (o_out.jobs_left)
);

// ===== tb/nfjt_checker.sv =====
// checker for the nearest-first job table: watches both channels, keeps its own
// copy of the job table, predicts every result and compares it field by field
// depends on nfjt_pkg and nfjt_if
module nfjt_checker #(
    parameter int TABLE_DEPTH = 64,
    parameter int COORD_BITS  = 24
) (
    input  logic i_clk,
    input  logic i_rst_n,
    nfjt_in_if   i_in_ch,
    nfjt_out_if  i_out_ch,
    output int   o_fail_count,
    output int   o_pending
);
    localparam int LEFT_BITS = $clog2(TABLE_DEPTH + 1);
    localparam int DIST_BITS = 2 * COORD_BITS + 1;
    localparam longint unsigned DIST_LIMIT = (64'd1 << DIST_BITS) - 64'd1;

    typedef struct {
        logic                          dropped;
        logic                          found;
        logic [nfjt_pkg::TAG_BITS-1:0] tag;
        logic [COORD_BITS-1:0]         x;
        logic [nfjt_pkg::Y_BITS-1:0]   y;
        logic [COORD_BITS-1:0]         z;
        logic [DIST_BITS-1:0]          dist_sq;
        logic [LEFT_BITS-1:0]          left;
    } t_job_outcome;

    logic signed [COORD_BITS-1:0]  held_x   [TABLE_DEPTH];
    logic [nfjt_pkg::Y_BITS-1:0]   held_y   [TABLE_DEPTH];
    logic signed [COORD_BITS-1:0]  held_z   [TABLE_DEPTH];
    logic [nfjt_pkg::TAG_BITS-1:0] held_tag [TABLE_DEPTH];
    int unsigned                   held_count;

    t_job_outcome awaited_outcomes[$];

    int fail_total    = 0;
    int results_seen  = 0;
    int inserts_seen  = 0;
    int drops_seen    = 0;
    int takes_seen    = 0;
    int empty_takes   = 0;
    int ties_seen     = 0;
    int saturations   = 0;
    int peak_fill     = 0;

    assign o_fail_count = fail_total;

    task automatic report(input string msg);
        fail_total++;
        if (fail_total <= 40) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            report($sformatf("result %0d: %s is %0h, wanted %0h",
                             results_seen, name, got, want));
        end
    endtask

    function automatic longint unsigned square_of(input longint d);
        longint unsigned m;
        m = (d < 0) ? -d : d;
        return m * m;
    endfunction

    // insert appends or drops; take scans for least squared distance, lowest index on tie,
    // then moves the last entry into the freed slot; a take on an empty table finds nothing
    function automatic t_job_outcome nearest_job_outcome(
        input logic                          func,
        input logic signed [COORD_BITS-1:0]  jx,
        input logic [nfjt_pkg::Y_BITS-1:0]   jy,
        input logic signed [COORD_BITS-1:0]  jz,
        input logic [nfjt_pkg::TAG_BITS-1:0] jtag,
        input logic signed [COORD_BITS-1:0]  vx,
        input logic signed [COORD_BITS-1:0]  vy,
        input logic signed [COORD_BITS-1:0]  vz
    );
        t_job_outcome    res;
        int unsigned     best;
        int unsigned     last;
        longint unsigned best_d;
        longint unsigned d;
        bit              tied;
        res = '{default: '0};
        if (func == nfjt_pkg::FUNC_INSERT) begin
            inserts_seen++;
            if (held_count >= TABLE_DEPTH) begin
                res.dropped = 1'b1;
                drops_seen++;
            end else begin
                held_x[held_count]   = jx;
                held_y[held_count]   = jy;
                held_z[held_count]   = jz;
                held_tag[held_count] = jtag;
                held_count++;
                if (held_count > peak_fill) begin
                    peak_fill = held_count;
                end
            end
        end else if (held_count > 0) begin
            takes_seen++;
            best   = 0;
            best_d = 0;
            tied   = 1'b0;
            for (int i = 0; i < held_count; i++) begin
                d = square_of(longint'(held_x[i]) - longint'(vx))
                  + square_of(longint'(held_y[i]) - longint'(vy))
                  + square_of(longint'(held_z[i]) - longint'(vz));
                if (i == 0 || d < best_d) begin
                    best   = i;
                    best_d = d;
                    tied   = 1'b0;
                end else if (d == best_d) begin
                    tied = 1'b1;
                end
            end
            if (tied) begin
                ties_seen++;
            end
            res.found = 1'b1;
            res.tag   = held_tag[best];
            res.x     = held_x[best];
            res.y     = held_y[best];
            res.z     = held_z[best];
            if (best_d > DIST_LIMIT) begin
                res.dist_sq = DIST_BITS'(DIST_LIMIT);
                saturations++;
            end else begin
                res.dist_sq = DIST_BITS'(best_d);
            end
            last = held_count - 1;
            held_x[best]   = held_x[last];
            held_y[best]   = held_y[last];
            held_z[best]   = held_z[last];
            held_tag[best] = held_tag[last];
            held_count     = last;
        end else begin
            takes_seen++;
            empty_takes++;
        end
        res.left = LEFT_BITS'(held_count);
        return res;
    endfunction

    task automatic print_coverage();
        $display("covered %0d inserts (%0d dropped on a full table, peak fill %0d of %0d)",
                 inserts_seen, drops_seen, peak_fill, TABLE_DEPTH);
        $display("covered %0d takes (%0d on an empty table, %0d ties, %0d saturated distances)",
                 takes_seen, empty_takes, ties_seen, saturations);
    endtask

    always @(posedge i_clk) begin
        t_job_outcome got;
        t_job_outcome want;
        if (!i_rst_n) begin
            held_count = 0;
            awaited_outcomes.delete();
        end else begin
            if (i_out_ch.valid === 1'b1 && i_out_ch.ready === 1'b1) begin
                results_seen++;
                got.dropped = i_out_ch.dropped;
                got.found   = i_out_ch.found;
                got.tag     = i_out_ch.out_tag;
                got.x       = i_out_ch.out_x;
                got.y       = i_out_ch.out_y;
                got.z       = i_out_ch.out_z;
                got.dist_sq = i_out_ch.out_dist_sq;
                got.left    = i_out_ch.jobs_left;
                if (awaited_outcomes.size() == 0) begin
                    report($sformatf("result %0d arrived with nothing outstanding",
                                     results_seen));
                end else begin
                    want = awaited_outcomes.pop_front();
                    check_field("dropped", got.dropped, want.dropped);
                    check_field("found", got.found, want.found);
                    check_field("out_tag", got.tag, want.tag);
                    check_field("out_x", got.x, want.x);
                    check_field("out_y", got.y, want.y);
                    check_field("out_z", got.z, want.z);
                    check_field("out_dist_sq", got.dist_sq, want.dist_sq);
                    check_field("jobs_left", got.left, want.left);
                end
            end
            if (i_in_ch.valid === 1'b1 && i_in_ch.ready === 1'b1) begin
                awaited_outcomes.push_back(nearest_job_outcome(
                    i_in_ch.func, i_in_ch.job_x, i_in_ch.job_y, i_in_ch.job_z,
                    i_in_ch.job_tag, i_in_ch.view_x, i_in_ch.view_y, i_in_ch.view_z));
            end
        end
        o_pending <= awaited_outcomes.size();
    end

endmodule

// ===== tb/tb_nearest_first_job_table_core.sv =====
// top of the job table testbench: clock, reset, directed and random item streams
// with sender and receiver idling, verdict from the checker's mismatch count
// depends on nfjt_pkg, nfjt_if, nfjt_checker and the block itself
module tb_nearest_first_job_table_core;
    localparam int TABLE_DEPTH  = 64;
    localparam int COORD_BITS   = 24;
    localparam int DIRECTED     = 16;
    localparam int RANDOM_ITEMS = 1750 - DIRECTED;
    localparam int TAIL_CYCLES  = TABLE_DEPTH + 16;

    localparam logic [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic [COORD_BITS-1:0] COORD_NEG1 = '1;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   tx_idle_pct = 33;
    int   rx_idle_pct = 54;

    nfjt_in_if  #(.COORD_BITS(COORD_BITS)) in_ch ();
    nfjt_out_if #(.COORD_BITS(COORD_BITS), .LEFT_BITS($clog2(TABLE_DEPTH + 1))) out_ch ();

    nearest_first_job_table_core #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COORD_BITS  (COORD_BITS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    nfjt_checker #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COORD_BITS  (COORD_BITS)
    ) u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_ch      (in_ch),
        .i_out_ch     (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    function automatic logic [COORD_BITS-1:0] pick_coord();
        int unsigned           kind;
        logic [COORD_BITS-1:0] c;
        kind = $urandom_range(99);
        if (kind < 50) begin
            c = COORD_BITS'(int'($urandom_range(8)) - 4);
        end else if (kind < 70) begin
            c = COORD_BITS'(int'($urandom_range(2000)) - 1000);
        end else if (kind < 85) begin
            c = COORD_BITS'($urandom());
        end else begin
            case ($urandom_range(3))
                0: c = COORD_MAX;
                1: c = COORD_MIN;
                2: c = COORD_NEG1;
                default: c = '0;
            endcase
        end
        return c;
    endfunction

    function automatic logic [nfjt_pkg::Y_BITS-1:0] pick_job_y();
        int unsigned kind;
        kind = $urandom_range(99);
        if (kind < 50) begin
            return nfjt_pkg::Y_BITS'($urandom_range(7));
        end else if (kind < 60) begin
            return $urandom_range(1) ? '1 : '0;
        end
        return nfjt_pkg::Y_BITS'($urandom_range(255));
    endfunction

    function automatic logic [COORD_BITS-1:0] pick_view_y();
        if ($urandom_range(99) < 50) begin
            return COORD_BITS'($urandom_range(7));
        end
        return pick_coord();
    endfunction

    task automatic send_item(
        input logic                          func,
        input logic [COORD_BITS-1:0]         jx,
        input logic [nfjt_pkg::Y_BITS-1:0]   jy,
        input logic [COORD_BITS-1:0]         jz,
        input logic [nfjt_pkg::TAG_BITS-1:0] jtag,
        input logic [COORD_BITS-1:0]         vx,
        input logic [COORD_BITS-1:0]         vy,
        input logic [COORD_BITS-1:0]         vz
    );
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.func    <= func;
        in_ch.job_x   <= jx;
        in_ch.job_y   <= jy;
        in_ch.job_z   <= jz;
        in_ch.job_tag <= jtag;
        in_ch.view_x  <= vx;
        in_ch.view_y  <= vy;
        in_ch.view_z  <= vz;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
    endtask

    task automatic insert_job(
        input logic [COORD_BITS-1:0]         jx,
        input logic [nfjt_pkg::Y_BITS-1:0]   jy,
        input logic [COORD_BITS-1:0]         jz,
        input logic [nfjt_pkg::TAG_BITS-1:0] jtag
    );
        send_item(nfjt_pkg::FUNC_INSERT, jx, jy, jz, jtag,
                  pick_coord(), pick_coord(), pick_coord());
    endtask

    task automatic take_job(
        input logic [COORD_BITS-1:0] vx,
        input logic [COORD_BITS-1:0] vy,
        input logic [COORD_BITS-1:0] vz
    );
        send_item(nfjt_pkg::FUNC_TAKE, pick_coord(), pick_job_y(), pick_coord(),
                  nfjt_pkg::TAG_BITS'($urandom_range(65535)), vx, vy, vz);
    endtask

    // sender stays quiet until every outstanding result is back
    task automatic hold_until_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        int mode;
        int burst_left;
        int insert_pct;
        mode       = 0;
        burst_left = 0;
        insert_pct = 50;
        i_rst_n       <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.func    <= nfjt_pkg::FUNC_INSERT;
        in_ch.job_x   <= '0;
        in_ch.job_y   <= '0;
        in_ch.job_z   <= '0;
        in_ch.job_tag <= '0;
        in_ch.view_x  <= '0;
        in_ch.view_y  <= '0;
        in_ch.view_z  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, extremes, saturated distance
        take_job(COORD_MIN, COORD_MAX, COORD_MAX);
        insert_job(COORD_MAX, 8'hFF, COORD_MIN, 16'hFFFF);
        insert_job(COORD_MIN, 8'h00, COORD_MAX, 16'h0000);
        take_job(COORD_MIN, COORD_MIN, COORD_MAX);
        take_job(COORD_MIN, COORD_MIN, COORD_MAX);
        take_job('0, '0, '0);
        // equal distances, lowest index wins
        insert_job(COORD_BITS'(1), 8'd5, COORD_BITS'(1), 16'h1111);
        insert_job(COORD_NEG1, 8'd5, COORD_NEG1, 16'h2222);
        insert_job(COORD_BITS'(1), 8'd5, COORD_NEG1, 16'h3333);
        take_job('0, COORD_BITS'(5), '0);
        take_job('0, COORD_BITS'(5), '0);
        take_job('0, COORD_BITS'(5), '0);
        // alternating bit patterns
        insert_job(24'h555555, 8'hAA, 24'hAAAAAA, 16'h5A5A);
        insert_job(24'hAAAAAA, 8'h55, 24'h555555, 16'hA5A5);
        take_job(24'h555555, 24'hAAAAAA, 24'hAAAAAA);
        take_job(COORD_MAX, COORD_MAX, COORD_MIN);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) begin
                hold_until_drained();
                tx_idle_pct = 54;
                rx_idle_pct = 33;
            end else if (n == 2 * RANDOM_ITEMS / 3) begin
                hold_until_drained();
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else if ($urandom_range(199) == 0) begin
                hold_until_drained();
            end
            // bursts that fill toward a full table, drain toward empty, or mix
            if (burst_left == 0) begin
                mode       = $urandom_range(2);
                burst_left = $urandom_range(20, 100);
                insert_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
            end
            burst_left--;
            if ($urandom_range(99) < insert_pct) begin
                insert_job(pick_coord(), pick_job_y(), pick_coord(),
                           nfjt_pkg::TAG_BITS'($urandom_range(65535)));
            end else begin
                take_job(pick_coord(), pick_view_y(), pick_coord());
            end
        end

        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        u_check.print_coverage();
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
